// File: rtl/wia_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
package wia_pkg;

  localparam int NUM_BYTES = 20;
  localparam int WIDTH     = NUM_BYTES * 8;
  localparam int WORD_W    = 64;
  localparam int BUS_W     = 3 * WORD_W;
  localparam int CNT_W     = $clog2(WIDTH);
  localparam int UPC_W     = 3;

  typedef enum logic [2:0] {
    MODE_ADD = 3'd0,
    MODE_SUB = 3'd1,
    MODE_CMP = 3'd2,
    MODE_MUL = 3'd3,
    MODE_DIV = 3'd4
  } mode_t;

  typedef enum logic [2:0] {
    OP_NONE,
    OP_ADD,
    OP_SUB,
    OP_CMP,
    OP_MUL,
    OP_DIV
  } op_t;

  typedef enum logic [1:0] {
    SQ_START,
    SQ_JUMP,
    SQ_LOOP
  } seq_t;

  localparam logic [UPC_W-1:0] UA_IDLE   = 3'd0;
  localparam logic [UPC_W-1:0] UA_ADD    = 3'd1;
  localparam logic [UPC_W-1:0] UA_SUB    = 3'd2;
  localparam logic [UPC_W-1:0] UA_CMP    = 3'd3;
  localparam logic [UPC_W-1:0] UA_MUL    = 3'd4;
  localparam logic [UPC_W-1:0] UA_DONE   = 3'd5;
  localparam logic [UPC_W-1:0] UA_DIV    = 3'd6;
  localparam logic [UPC_W-1:0] UA_DIVEND = 3'd7;

  typedef struct packed {
    op_t              op;
    seq_t             seq;
    logic [UPC_W-1:0] target;
    logic             done;
  } uword_t;

  typedef struct packed {
    logic load;
    op_t  op;
  } dp_ctl_t;

  // Microprogram. LOOP repeats at target while the bit counter is non-zero,
  // then falls through to the next address.
  function automatic uword_t ucode(input logic [UPC_W-1:0] addr);
    uword_t w;
    case (addr)
      UA_IDLE:   w = '{op: OP_NONE, seq: SQ_START, target: UA_IDLE,   done: 1'b0};
      UA_ADD:    w = '{op: OP_ADD,  seq: SQ_JUMP,  target: UA_DONE,   done: 1'b0};
      UA_SUB:    w = '{op: OP_SUB,  seq: SQ_JUMP,  target: UA_DONE,   done: 1'b0};
      UA_CMP:    w = '{op: OP_CMP,  seq: SQ_JUMP,  target: UA_DONE,   done: 1'b0};
      UA_MUL:    w = '{op: OP_MUL,  seq: SQ_LOOP,  target: UA_MUL,    done: 1'b0};
      UA_DONE:   w = '{op: OP_NONE, seq: SQ_JUMP,  target: UA_IDLE,   done: 1'b1};
      UA_DIV:    w = '{op: OP_DIV,  seq: SQ_LOOP,  target: UA_DIV,    done: 1'b0};
      UA_DIVEND: w = '{op: OP_NONE, seq: SQ_JUMP,  target: UA_DONE,   done: 1'b0};
      default:   w = '{op: OP_NONE, seq: SQ_JUMP,  target: UA_IDLE,   done: 1'b0};
    endcase
    return w;
  endfunction

endpackage
`default_nettype wire

// File: rtl/wia_useq.sv
`timescale 1ns / 1ps
`default_nettype none
module wia_useq (
  input  wire logic                 clk,
  input  wire logic                 rst_n,
  input  wire logic                 start,
  input  wire logic [2:0]           in_mode,
  output wia_pkg::dp_ctl_t          dp_ctl,
  output logic                      busy,
  output logic                      done
);

  logic [wia_pkg::UPC_W-1:0] upc_r, upc_nxt;
  logic [wia_pkg::CNT_W-1:0] cnt_r, cnt_nxt;
  wia_pkg::uword_t           uw;
  logic [wia_pkg::UPC_W-1:0] entry;

  assign uw = wia_pkg::ucode(upc_r);

  always_comb begin
    case (in_mode)
      wia_pkg::MODE_ADD: entry = wia_pkg::UA_ADD;
      wia_pkg::MODE_SUB: entry = wia_pkg::UA_SUB;
      wia_pkg::MODE_CMP: entry = wia_pkg::UA_CMP;
      wia_pkg::MODE_MUL: entry = wia_pkg::UA_MUL;
      wia_pkg::MODE_DIV: entry = wia_pkg::UA_DIV;
      default:           entry = wia_pkg::UA_DONE;
    endcase
  end

  always_comb begin
    upc_nxt     = upc_r;
    cnt_nxt     = cnt_r;
    dp_ctl.load = 1'b0;
    dp_ctl.op   = uw.op;
    case (uw.seq)
      wia_pkg::SQ_START: begin
        if (start) begin
          upc_nxt     = entry;
          cnt_nxt     = wia_pkg::CNT_W'(wia_pkg::WIDTH - 1);
          dp_ctl.load = 1'b1;
        end
      end
      wia_pkg::SQ_JUMP: upc_nxt = uw.target;
      wia_pkg::SQ_LOOP: begin
        if (cnt_r != '0) begin
          cnt_nxt = cnt_r - 1'b1;
          upc_nxt = uw.target;
        end else begin
          upc_nxt = upc_r + 1'b1;
        end
      end
      default: upc_nxt = wia_pkg::UA_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      upc_r <= wia_pkg::UA_IDLE;
      cnt_r <= '0;
    end else begin
      upc_r <= upc_nxt;
      cnt_r <= cnt_nxt;
    end
  end

  assign busy = (upc_r != wia_pkg::UA_IDLE);
  assign done = uw.done;

endmodule
`default_nettype wire

// File: rtl/wia_datapath.sv
`timescale 1ns / 1ps
`default_nettype none
module wia_datapath (
  input  wire logic                      clk,
  input  wire wia_pkg::dp_ctl_t          dp_ctl,
  input  wire logic [2:0]                in_mode,
  input  wire logic [wia_pkg::BUS_W-1:0] a_bus,
  input  wire logic [wia_pkg::BUS_W-1:0] b_bus,
  output logic [wia_pkg::WIDTH-1:0]      q_out,
  output logic [wia_pkg::WIDTH-1:0]      r_out,
  output logic                           lt_out,
  output logic                           dz_out
);

  localparam int W = wia_pkg::WIDTH;

  logic [W-1:0] a_in, b_in;
  logic [W-1:0] x_r, x_nxt, y_r, y_nxt, q_r, q_nxt, r_r, r_nxt;
  logic         lt_r, lt_nxt, dz_r, dz_nxt;
  logic [W:0]   rs;
  logic [W+1:0] rdiff;
  logic         ge;

  assign a_in  = W'(a_bus);
  assign b_in  = W'(b_bus);
  // restoring step: shift next dividend bit into the partial remainder
  assign rs    = {r_r, x_r[W-1]};
  assign rdiff = {1'b0, rs} - {2'b00, y_r};
  assign ge    = ~rdiff[W+1];

  always_comb begin
    x_nxt  = x_r;
    y_nxt  = y_r;
    q_nxt  = q_r;
    r_nxt  = r_r;
    lt_nxt = lt_r;
    dz_nxt = dz_r;
    if (dp_ctl.load) begin
      x_nxt  = a_in;
      y_nxt  = b_in;
      q_nxt  = '0;
      r_nxt  = '0;
      lt_nxt = 1'b0;
      dz_nxt = (in_mode == wia_pkg::MODE_DIV) && (b_in == '0);
    end else begin
      case (dp_ctl.op)
        wia_pkg::OP_ADD: q_nxt = x_r + y_r;
        wia_pkg::OP_SUB: q_nxt = x_r - y_r;
        wia_pkg::OP_CMP: lt_nxt = (x_r < y_r);
        wia_pkg::OP_MUL: begin
          q_nxt = q_r + (x_r[0] ? y_r : '0);
          x_nxt = x_r >> 1;
          y_nxt = y_r << 1;
        end
        wia_pkg::OP_DIV: begin
          x_nxt = x_r << 1;
          r_nxt = ge ? rdiff[W-1:0] : rs[W-1:0];
          q_nxt = {q_r[W-2:0], ge};
        end
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    x_r  <= x_nxt;
    y_r  <= y_nxt;
    q_r  <= q_nxt;
    r_r  <= r_nxt;
    lt_r <= lt_nxt;
    dz_r <= dz_nxt;
  end

  assign q_out  = q_r;
  assign r_out  = r_r;
  assign lt_out = lt_r;
  assign dz_out = dz_r;

endmodule
`default_nettype wire

// File: rtl/wide_integer_alu.sv
// Wide unsigned ALU (160-bit operands): add, subtract, compare, multiply
// (low half) and divide (quotient and remainder), one item at a time.
// An item is taken when start is high and busy is low; its result is shown
// for one cycle with out_valid and cannot be held off by the receiver.
// Multiply and divide loop: the microprogram steps the shared
// shift/add-subtract datapath once per operand bit. Unused mode codes give
// an all-zero result.
// Divide by zero returns an all-ones quotient, remainder a, and flags it.
`timescale 1ns / 1ps
`default_nettype none
module wide_integer_alu (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        start,
  output logic             busy,
  input  wire logic [2:0]  in_mode,
  input  wire logic [63:0] in_a_word0,
  input  wire logic [63:0] in_a_word1,
  input  wire logic [63:0] in_a_word2,
  input  wire logic [63:0] in_b_word0,
  input  wire logic [63:0] in_b_word1,
  input  wire logic [63:0] in_b_word2,
  output logic             out_valid,
  output logic [63:0]      out_result_word0,
  output logic [63:0]      out_result_word1,
  output logic [63:0]      out_result_word2,
  output logic [63:0]      out_remainder_word0,
  output logic [63:0]      out_remainder_word1,
  output logic [63:0]      out_remainder_word2,
  output logic             out_less_than,
  output logic             out_divide_by_zero
);

  wia_pkg::dp_ctl_t              dp_ctl;
  logic [wia_pkg::WIDTH-1:0]     q, r;
  logic [wia_pkg::BUS_W-1:0]     q_ext, r_ext;

  wia_useq u_useq (
    .clk     (clk),
    .rst_n   (rst_n),
    .start   (start),
    .in_mode (in_mode),
    .dp_ctl  (dp_ctl),
    .busy    (busy),
    .done    (out_valid)
  );

  wia_datapath u_dp (
    .clk     (clk),
    .dp_ctl  (dp_ctl),
    .in_mode (in_mode),
    .a_bus   ({in_a_word2, in_a_word1, in_a_word0}),
    .b_bus   ({in_b_word2, in_b_word1, in_b_word0}),
    .q_out   (q),
    .r_out   (r),
    .lt_out  (out_less_than),
    .dz_out  (out_divide_by_zero)
  );

  assign q_ext = wia_pkg::BUS_W'(q);
  assign r_ext = wia_pkg::BUS_W'(r);

  assign out_result_word0    = q_ext[63:0];
  assign out_result_word1    = q_ext[127:64];
  assign out_result_word2    = q_ext[191:128];
  assign out_remainder_word0 = r_ext[63:0];
  assign out_remainder_word1 = r_ext[127:64];
  assign out_remainder_word2 = r_ext[191:128];

endmodule
`default_nettype wire

// File: rtl/wia_checker.sv
`timescale 1ns / 1ps
`default_nettype none
module wia_checker (
  input wire logic        clk,
  input wire logic        rst_n,
  input wire logic        start,
  input wire logic        busy,
  input wire logic        out_valid,
  input wire logic [63:0] out_result_word0,
  input wire logic [63:0] out_result_word1,
  input wire logic [63:0] out_result_word2,
  input wire logic        out_less_than,
  input wire logic        out_divide_by_zero
);

  a_reset_idle: assert property (@(posedge clk) !rst_n |=> !busy && !out_valid)
    else $error("not idle after reset");

  a_take_busy: assert property (@(posedge clk) disable iff (!rst_n)
    start && !busy |=> busy)
    else $error("transfer accepted but block not busy");

  a_strobe_single: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |=> !out_valid && !busy)
    else $error("result strobe longer than one cycle");

  a_valid_busy: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> busy)
    else $error("result shown while idle");

  a_cmp_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_less_than |-> out_result_word0 == 64'd0 &&
      out_result_word1 == 64'd0 && out_result_word2 == 64'd0 && !out_divide_by_zero)
    else $error("compare result carries a main result");

endmodule

bind wide_integer_alu wia_checker u_wia_checker (.*);
`default_nettype wire

// File: sim/wia_checker.sv
`timescale 1ns / 1ps
module wia_scoreboard (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        start,
  input  wire logic        busy,
  input  wire logic [2:0]  in_mode,
  input  wire logic [63:0] in_a_word0,
  input  wire logic [63:0] in_a_word1,
  input  wire logic [63:0] in_a_word2,
  input  wire logic [63:0] in_b_word0,
  input  wire logic [63:0] in_b_word1,
  input  wire logic [63:0] in_b_word2,
  input  wire logic        out_valid,
  input  wire logic [63:0] out_result_word0,
  input  wire logic [63:0] out_result_word1,
  input  wire logic [63:0] out_result_word2,
  input  wire logic [63:0] out_remainder_word0,
  input  wire logic [63:0] out_remainder_word1,
  input  wire logic [63:0] out_remainder_word2,
  input  wire logic        out_less_than,
  input  wire logic        out_divide_by_zero,
  output int               fail_count,
  output int               checked_count,
  output int               outstanding
);

  typedef struct packed {
    logic [wia_pkg::BUS_W-1:0] value;
    logic [wia_pkg::BUS_W-1:0] remainder;
    logic                      lt;
    logic                      dz;
  } alu_result_t;

  alu_result_t expected_results[$];

  // Operands are cut to WIDTH bits; everything above WIDTH in the result is zero.
  function automatic alu_result_t compute_alu_result(
      input logic [2:0]                mode,
      input logic [wia_pkg::BUS_W-1:0] a_bus,
      input logic [wia_pkg::BUS_W-1:0] b_bus);
    logic [wia_pkg::WIDTH-1:0] a;
    logic [wia_pkg::WIDTH-1:0] b;
    logic [wia_pkg::WIDTH-1:0] q;
    logic [wia_pkg::WIDTH-1:0] r;
    alu_result_t res;
    a = a_bus[wia_pkg::WIDTH-1:0];
    b = b_bus[wia_pkg::WIDTH-1:0];
    q = '0;
    r = '0;
    res = '0;
    case (mode)
      wia_pkg::MODE_ADD: q = a + b;
      wia_pkg::MODE_SUB: q = a - b;
      wia_pkg::MODE_CMP: res.lt = (a < b);
      wia_pkg::MODE_MUL: q = a * b;
      wia_pkg::MODE_DIV: begin
        if (b == '0) begin
          q = '1;
          r = a;
          res.dz = 1'b1;
        end else begin
          q = a / b;
          r = a % b;
        end
      end
      default: ;
    endcase
    res.value[wia_pkg::WIDTH-1:0] = q;
    res.remainder[wia_pkg::WIDTH-1:0] = r;
    return res;
  endfunction

  task automatic report_failure(input string what);
    fail_count++;
    if (fail_count <= 10) $display("%0t: %s", $time, what);
  endtask

  task automatic check_field(input string name, input logic [63:0] want,
                             input logic [63:0] got);
    if (got !== want)
      report_failure($sformatf("%s mismatch: expected %h, got %h", name, want, got));
  endtask

  always @(posedge clk) begin
    alu_result_t want;
    if (rst_n) begin
      if (start && !busy)
        expected_results.push_back(compute_alu_result(in_mode,
          {in_a_word2, in_a_word1, in_a_word0}, {in_b_word2, in_b_word1, in_b_word0}));
      if (out_valid) begin
        if (expected_results.size() == 0) begin
          report_failure("result transfer with nothing outstanding");
        end else begin
          want = expected_results.pop_front();
          checked_count++;
          check_field("result_word0", want.value[63:0], out_result_word0);
          check_field("result_word1", want.value[127:64], out_result_word1);
          check_field("result_word2", want.value[191:128], out_result_word2);
          check_field("remainder_word0", want.remainder[63:0], out_remainder_word0);
          check_field("remainder_word1", want.remainder[127:64], out_remainder_word1);
          check_field("remainder_word2", want.remainder[191:128], out_remainder_word2);
          check_field("less_than", 64'(want.lt), 64'(out_less_than));
          check_field("divide_by_zero", 64'(want.dz), 64'(out_divide_by_zero));
        end
      end
    end
    outstanding <= expected_results.size();
  end

endmodule

// File: sim/tb.sv
`timescale 1ns / 1ps
module tb;

  localparam int STALL_LIMIT = 4000;
  localparam int RANDOM_OPS  = 1550;

  logic        clk;
  logic        rst_n;
  logic        start;
  logic        busy;
  logic [2:0]  in_mode;
  logic [63:0] in_a_word0, in_a_word1, in_a_word2;
  logic [63:0] in_b_word0, in_b_word1, in_b_word2;
  logic        out_valid;
  logic [63:0] out_result_word0, out_result_word1, out_result_word2;
  logic [63:0] out_remainder_word0, out_remainder_word1, out_remainder_word2;
  logic        out_less_than;
  logic        out_divide_by_zero;

  int fail_count;
  int checked_count;
  int outstanding;
  int idle_cycles;
  int ops_per_mode[8];
  bit no_gaps;

  wide_integer_alu uut (.*);

  wia_scoreboard u_check (.*);

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  always @(posedge clk) begin
    if ((start && !busy) || out_valid) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= STALL_LIMIT) begin
      $display("Watchdog: no transfer for %0d cycles", STALL_LIMIT);
      $display("Testbench completed WITH ERRORS");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  function automatic logic [wia_pkg::BUS_W-1:0] rand_wide();
    return {$urandom, $urandom, $urandom, $urandom, $urandom, $urandom};
  endfunction

  function automatic logic [wia_pkg::BUS_W-1:0] pick_operand();
    logic [wia_pkg::BUS_W-1:0] v;
    case ($urandom_range(0, 11))
      0: v = '0;
      1: v = '1;
      2: v = wia_pkg::BUS_W'($urandom_range(0, 255));
      3: v = wia_pkg::BUS_W'(1) << $urandom_range(0, wia_pkg::BUS_W - 1);
      4: v = wia_pkg::BUS_W'({$urandom, $urandom}) << (64 * $urandom_range(0, 2));
      5: v = rand_wide() >> $urandom_range(0, wia_pkg::BUS_W - 1);
      6: v = '1 >> $urandom_range(0, wia_pkg::BUS_W - 1);
      default: v = rand_wide();
    endcase
    return v;
  endfunction

  function automatic logic [2:0] pick_mode();
    int r;
    r = $urandom_range(0, 99);
    if (r < 16) return wia_pkg::MODE_ADD;
    if (r < 32) return wia_pkg::MODE_SUB;
    if (r < 48) return wia_pkg::MODE_CMP;
    if (r < 70) return wia_pkg::MODE_MUL;
    if (r < 94) return wia_pkg::MODE_DIV;
    return 3'($urandom_range(int'(wia_pkg::MODE_DIV) + 1, 7));
  endfunction

  task automatic issue_op(input logic [2:0] m, input logic [wia_pkg::BUS_W-1:0] a,
                          input logic [wia_pkg::BUS_W-1:0] b);
    start      <= 1'b1;
    in_mode    <= m;
    in_a_word0 <= a[63:0];
    in_a_word1 <= a[127:64];
    in_a_word2 <= a[191:128];
    in_b_word0 <= b[63:0];
    in_b_word1 <= b[127:64];
    in_b_word2 <= b[191:128];
    @(posedge clk);
    while (busy) @(posedge clk);
    ops_per_mode[m]++;
  endtask

  // Gaps are put in between operations and may run longer than a multiply.
  task automatic maybe_idle();
    int len;
    if (!no_gaps && $urandom_range(0, 99) < 14) begin
      len = ($urandom_range(0, 3) == 0) ? $urandom_range(1, 200) : $urandom_range(1, 6);
      start <= 1'b0;
      repeat (len) @(posedge clk);
    end
  endtask

  initial begin
    logic [wia_pkg::BUS_W-1:0] top_ones;
    logic [wia_pkg::BUS_W-1:0] above_width;
    logic [wia_pkg::BUS_W-1:0] a;
    logic [wia_pkg::BUS_W-1:0] b;
    logic [2:0]                m;
    top_ones    = '1;
    above_width = top_ones << wia_pkg::WIDTH;
    rst_n      <= 1'b0;
    start      <= 1'b0;
    in_mode    <= wia_pkg::MODE_ADD;
    in_a_word0 <= '0;
    in_a_word1 <= '0;
    in_a_word2 <= '0;
    in_b_word0 <= '0;
    in_b_word1 <= '0;
    in_b_word2 <= '0;
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed: wrap-around, carries across words, compare edges, mul/div corners
    issue_op(wia_pkg::MODE_ADD, top_ones, wia_pkg::BUS_W'(1));
    issue_op(wia_pkg::MODE_ADD, wia_pkg::BUS_W'(64'hFFFF_FFFF_FFFF_FFFF),
             wia_pkg::BUS_W'(1));
    issue_op(wia_pkg::MODE_SUB, '0, wia_pkg::BUS_W'(1));
    a = rand_wide();
    issue_op(wia_pkg::MODE_SUB, a, a);
    issue_op(wia_pkg::MODE_CMP, top_ones, top_ones);
    issue_op(wia_pkg::MODE_CMP, wia_pkg::BUS_W'(5), wia_pkg::BUS_W'(6));
    issue_op(wia_pkg::MODE_CMP, wia_pkg::BUS_W'(6), wia_pkg::BUS_W'(5));
    issue_op(wia_pkg::MODE_CMP, above_width, wia_pkg::BUS_W'(1));
    issue_op(wia_pkg::MODE_MUL, top_ones, top_ones);
    issue_op(wia_pkg::MODE_MUL, '0, rand_wide());
    issue_op(wia_pkg::MODE_MUL, wia_pkg::BUS_W'(1), rand_wide());
    issue_op(wia_pkg::MODE_MUL, rand_wide(), rand_wide());
    issue_op(wia_pkg::MODE_DIV, rand_wide(), '0);
    issue_op(wia_pkg::MODE_DIV, '0, above_width);
    issue_op(wia_pkg::MODE_DIV, wia_pkg::BUS_W'(7), rand_wide());
    a = rand_wide();
    issue_op(wia_pkg::MODE_DIV, a, a);
    issue_op(wia_pkg::MODE_DIV, top_ones, wia_pkg::BUS_W'(1));
    issue_op(wia_pkg::MODE_DIV, top_ones, wia_pkg::BUS_W'(1) << (wia_pkg::WIDTH - 1));
    issue_op(wia_pkg::MODE_DIV, top_ones, top_ones);
    for (int s = int'(wia_pkg::MODE_DIV) + 1; s < 8; s++)
      issue_op(3'(s), rand_wide(), rand_wide());

    for (int i = 0; i < RANDOM_OPS; i++) begin
      no_gaps = (i >= 600 && i < 900);
      m = pick_mode();
      a = pick_operand();
      b = pick_operand();
      if (m == wia_pkg::MODE_DIV && $urandom_range(0, 3) == 0)
        b = a >> $urandom_range(0, wia_pkg::WIDTH - 1);
      issue_op(m, a, b);
      maybe_idle();
    end
    start <= 1'b0;

    @(posedge clk);
    while (outstanding != 0) @(posedge clk);
    repeat (170) @(posedge clk);

    $display("Sent %0d add, %0d sub, %0d cmp, %0d mul, %0d div, %0d spare-mode operations",
             ops_per_mode[wia_pkg::MODE_ADD], ops_per_mode[wia_pkg::MODE_SUB],
             ops_per_mode[wia_pkg::MODE_CMP], ops_per_mode[wia_pkg::MODE_MUL],
             ops_per_mode[wia_pkg::MODE_DIV],
             ops_per_mode[5] + ops_per_mode[6] + ops_per_mode[7]);
    $display("%0d results checked, %0d failures", checked_count, fail_count);
    if (fail_count == 0 && outstanding == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule

// File: filelist.f
rtl/wia_pkg.sv
rtl/wia_useq.sv
rtl/wia_datapath.sv
rtl/wide_integer_alu.sv
rtl/wia_checker.sv
sim/wia_checker.sv
sim/tb.sv
